// ===== rtl/core/dws_pkg.sv =====
// Shared constants, codes and types for the damped wave stencil block.
package dws_pkg;

    // Default sample width (signed fixed point)
    localparam int VALUE_BITS_DEF = 32;

    // Gain registers: unsigned, 24 fraction bits
    localparam int GAIN_W    = 25;
    localparam int GAIN_FRAC = 24;

    localparam logic [GAIN_W-1:0] LAP_GAIN_RESET  = GAIN_W'(4194304);
    localparam logic [GAIN_W-1:0] DAMP_GAIN_RESET = '0;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAP_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_GAIN = 1'b1;

    // Command queue depth between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Window fill state of the front end
    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,  // awaiting the first point of a sweep
        PH_EDGE   = 2'd1,  // boundary point seen
        PH_WINDOW = 2'd2   // window holds left and center
    } t_phase;

    // Command flags passed from front to back
    typedef struct packed {
        logic zero;       // result is a boundary zero
        logic sweep_end;  // result closes the sweep
        logic tail;       // inner result followed by the closing boundary zero
    } t_cmd_flags;

endpackage

// ===== rtl/core/dws_fifo.sv =====
// Small register queue carrying stencil commands from front to back.
module dws_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = dws_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_not_full,
    input  logic              i_pop,
    output logic              o_head_valid,
    output logic [DATA_W-1:0] o_head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_store [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_not_full   = (r_count != CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_data  = r_store[r_rd_ptr];

endmodule

// ===== rtl/core/dws_front.sv =====
// Front end: accepts grid points, keeps the three-point window, issues commands.
module dws_front #(
    parameter int VALUE_BITS = dws_pkg::VALUE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input point channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [VALUE_BITS-1:0]   i_cur_value,
    input  logic [VALUE_BITS-1:0]   i_old_value,
    input  logic                    i_last_point,
    // command queue side
    input  logic                    i_q_not_full,
    output logic                    o_push,
    output dws_pkg::t_cmd_flags     o_flags,
    output logic [VALUE_BITS-1:0]   o_left,
    output logic [VALUE_BITS-1:0]   o_center,
    output logic [VALUE_BITS-1:0]   o_old,
    output logic [VALUE_BITS-1:0]   o_right
);

    dws_pkg::t_phase r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_left;
    logic [VALUE_BITS-1:0] r_center;
    logic [VALUE_BITS-1:0] r_old;
    logic w_accept;

    // Every accepted point yields at most one command
    assign o_in_ready = i_q_not_full;
    assign w_accept   = i_in_valid && i_q_not_full;

    // Next state
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            unique case (r_phase)
                dws_pkg::PH_EDGE:   n_phase = i_last_point ? dws_pkg::PH_WAIT
                                                           : dws_pkg::PH_WINDOW;
                dws_pkg::PH_WINDOW: n_phase = i_last_point ? dws_pkg::PH_WAIT
                                                           : dws_pkg::PH_WINDOW;
                default:            n_phase = i_last_point ? dws_pkg::PH_WAIT
                                                           : dws_pkg::PH_EDGE;
            endcase
        end
    end

    // Command outputs
    always_comb begin
        o_push  = 1'b0;
        o_flags = '0;
        o_right = '0;
        unique case (r_phase)
            dws_pkg::PH_WINDOW: begin
                // inner point; the final point is a zero boundary neighbor
                o_push       = w_accept;
                o_flags.tail = i_last_point;
                o_right      = i_last_point ? '0 : i_cur_value;
            end
            dws_pkg::PH_EDGE: begin
                // two-point sweep closes here
                o_push            = w_accept && i_last_point;
                o_flags.zero      = 1'b1;
                o_flags.sweep_end = 1'b1;
            end
            default: begin
                // first point is a boundary
                o_push            = w_accept;
                o_flags.zero      = 1'b1;
                o_flags.sweep_end = i_last_point;
            end
        endcase
    end

    assign o_left   = r_left;
    assign o_center = r_center;
    assign o_old    = r_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dws_pkg::PH_WAIT;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Window shift
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            case (r_phase)
                dws_pkg::PH_EDGE: begin
                    if (!i_last_point) begin
                        r_center <= i_cur_value;
                        r_old    <= i_old_value;
                    end
                end
                dws_pkg::PH_WINDOW: begin
                    if (!i_last_point) begin
                        r_left   <= r_center;
                        r_center <= i_cur_value;
                        r_old    <= i_old_value;
                    end
                end
                default: begin
                    r_left <= '0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/dws_back.sv =====
// Back end: stencil arithmetic pipeline with saturation and output register.
module dws_back #(
    parameter int VALUE_BITS = dws_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [dws_pkg::GAIN_W-1:0]     i_lap_gain,
    input  logic [dws_pkg::GAIN_W-1:0]     i_damp_gain,
    // command queue head
    input  logic                           i_head_valid,
    input  dws_pkg::t_cmd_flags            i_head_flags,
    input  logic [VALUE_BITS-1:0]          i_left,
    input  logic [VALUE_BITS-1:0]          i_center,
    input  logic [VALUE_BITS-1:0]          i_old,
    input  logic [VALUE_BITS-1:0]          i_right,
    output logic                           o_pop,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [VALUE_BITS-1:0]          o_next_value,
    output logic                           o_sweep_end
);

    localparam int GW  = dws_pkg::GAIN_W;
    localparam int LW  = VALUE_BITS + 2;      // laplacian / base width
    localparam int LO  = LW / 2;              // low partial operand
    localparam int HI  = LW - LO;             // high partial operand (signed)
    localparam int LPW = LO + GW;             // low product
    localparam int HPW = HI + GW + 1;         // high product
    localparam int PW  = LW + GW;             // full product
    localparam int TW  = PW - dws_pkg::GAIN_FRAC;
    localparam int SW  = TW + 2;

    logic w_en;
    logic r_tail_pend;
    dws_pkg::t_cmd_flags w_issue_flags;

    // stage 1: differences
    logic                r_s1_valid;
    dws_pkg::t_cmd_flags r_s1_flags;
    logic [LW-1:0]       r_s1_lap, r_s1_fr, r_s1_base;
    logic [LW-1:0]       n_lap, n_fr, n_base;
    logic [LW-1:0]       w_l, w_c, w_o, w_r;

    // stage 2: partial products
    logic                r_s2_valid;
    dws_pkg::t_cmd_flags r_s2_flags;
    logic [LW-1:0]       r_s2_base;
    logic [LPW-1:0]      r_lap_lp, r_fr_lp;
    logic [HPW-1:0]      r_lap_hp, r_fr_hp;

    // stage 3: floored gain terms
    logic                r_s3_valid;
    dws_pkg::t_cmd_flags r_s3_flags;
    logic [LW-1:0]       r_s3_base;
    logic [TW-1:0]       r_lap_term, r_fr_term;
    logic [PW-1:0]       w_lap_full, w_fr_full;

    // output register
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_end;
    logic [SW-1:0]         w_sum;
    logic                  w_ovf;
    logic [VALUE_BITS-1:0] n_out_value;

    // Whole pipeline advances unless a finished result is stalled
    assign w_en = !r_out_valid || i_out_ready;

    // A tail command issues twice: inner result, then closing zero
    assign o_pop = w_en && i_head_valid && !(i_head_flags.tail && !r_tail_pend);

    always_comb begin
        w_issue_flags           = i_head_flags;
        w_issue_flags.zero      = i_head_flags.zero || r_tail_pend;
        w_issue_flags.sweep_end = i_head_flags.sweep_end || r_tail_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_pend <= 1'b0;
        end else if (w_en && i_head_valid && i_head_flags.tail) begin
            r_tail_pend <= !r_tail_pend;
        end
    end

    // Stage 1 arithmetic
    always_comb begin
        w_l    = {{2{i_left[VALUE_BITS-1]}},   i_left};
        w_c    = {{2{i_center[VALUE_BITS-1]}}, i_center};
        w_o    = {{2{i_old[VALUE_BITS-1]}},    i_old};
        w_r    = {{2{i_right[VALUE_BITS-1]}},  i_right};
        n_lap  = w_l + w_r - {w_c[LW-2:0], 1'b0};
        n_fr   = w_c - w_o;
        n_base = {w_c[LW-2:0], 1'b0} - w_o;
    end

    // Stage 3 recombination; dropping the low bits floors the term
    always_comb begin
        w_lap_full = {r_lap_hp[HI+GW-1:0], {LO{1'b0}}} + {{HI{1'b0}}, r_lap_lp};
        w_fr_full  = {r_fr_hp[HI+GW-1:0],  {LO{1'b0}}} + {{HI{1'b0}}, r_fr_lp};
    end

    // Final sum and saturation
    always_comb begin
        w_sum = {{(SW-LW){r_s3_base[LW-1]}}, r_s3_base}
              + {{2{r_lap_term[TW-1]}}, r_lap_term}
              - {{2{r_fr_term[TW-1]}}, r_fr_term};
        w_ovf = !((&w_sum[SW-1:VALUE_BITS-1]) || !(|w_sum[SW-1:VALUE_BITS-1]));
        if (r_s3_flags.zero) begin
            n_out_value = '0;
        end else if (w_ovf) begin
            n_out_value = w_sum[SW-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                      : {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else begin
            n_out_value = w_sum[VALUE_BITS-1:0];
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= i_head_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_flags <= w_issue_flags;
            r_s1_lap   <= n_lap;
            r_s1_fr    <= n_fr;
            r_s1_base  <= n_base;

            r_s2_flags <= r_s1_flags;
            r_s2_base  <= r_s1_base;
            r_lap_lp   <= {{GW{1'b0}}, r_s1_lap[LO-1:0]} * {{LO{1'b0}}, i_lap_gain};
            r_fr_lp    <= {{GW{1'b0}}, r_s1_fr[LO-1:0]}  * {{LO{1'b0}}, i_damp_gain};
            r_lap_hp   <= HPW'($signed({{(GW+1){r_s1_lap[LW-1]}}, r_s1_lap[LW-1:LO]})
                             * $signed({{(HI+1){1'b0}}, i_lap_gain}));
            r_fr_hp    <= HPW'($signed({{(GW+1){r_s1_fr[LW-1]}}, r_s1_fr[LW-1:LO]})
                             * $signed({{(HI+1){1'b0}}, i_damp_gain}));

            r_s3_flags <= r_s2_flags;
            r_s3_base  <= r_s2_base;
            r_lap_term <= w_lap_full[PW-1:dws_pkg::GAIN_FRAC];
            r_fr_term  <= w_fr_full[PW-1:dws_pkg::GAIN_FRAC];

            r_out_value <= n_out_value;
            r_out_end   <= r_s3_flags.sweep_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_next_value = r_out_value;
    assign o_sweep_end  = r_out_end;

    // The pending second half belongs to the queue head that is still held
    a_tail_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_pend |-> (i_head_valid && i_head_flags.tail))
        else $error("tail pending without a tail command at queue head");

    // Queue is only popped when it holds a command
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop from empty command queue");

    // Second half of a tail command is the closing boundary zero
    a_tail_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail_pend && w_en) |=> (r_s1_valid && r_s1_flags.zero && r_s1_flags.sweep_end))
        else $error("closing zero not issued after tail command");

endmodule

// ===== rtl/core/damped_wave_stencil_step.sv =====
// Top level of the damped 1-D wave leapfrog stencil block.
//
// Usage: grid points of one sweep enter in order on the input channel
// (i_in_valid / o_in_ready) with current value, previous value and a
// last-point mark. One result per grid point leaves on the output channel
// (o_out_valid / i_out_ready) in grid order; both boundary results are zero.
// The result for an inner point is produced when its right neighbor arrives;
// the final point produces two results (last inner point, then the closing
// zero with o_sweep_end set).
// Throughput: one point per cycle while the queue has room; the final point of
// a sweep is issued twice by the back end, since its arithmetic pipeline
// retires one result per cycle while the output is not stalled and that point
// carries two. A 4-entry command queue lets the input keep running while the
// receiver stalls; when it fills, o_in_ready drops. A stalled result holds
// steady. Gains are written on the configuration channel (always ready) while
// the block is idle; the user must ensure this, the block does not enforce it.
// Synchronous reset empties the pipeline and queue, restarts the sweep and
// loads the default gains (lap_gain 1/4, damp_gain 0).
module damped_wave_stencil_step #(
    parameter int VALUE_BITS = dws_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dws_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dws_pkg::GAIN_W-1:0]      i_cfg_data,
    // input point channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [VALUE_BITS-1:0]    i_cur_value,
    input  logic signed [VALUE_BITS-1:0]    i_old_value,
    input  logic                            i_last_point,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [VALUE_BITS-1:0]    o_next_value,
    output logic                            o_sweep_end
);

    localparam int FLAG_W = $bits(dws_pkg::t_cmd_flags);
    localparam int CMD_W  = FLAG_W + 4 * VALUE_BITS;

    logic [dws_pkg::GAIN_W-1:0] r_lap_gain;
    logic [dws_pkg::GAIN_W-1:0] r_damp_gain;

    logic                  w_push;
    dws_pkg::t_cmd_flags   w_push_flags;
    logic [VALUE_BITS-1:0] w_left, w_center, w_old, w_right;
    logic                  w_q_not_full;
    logic                  w_pop;
    logic                  w_head_valid;
    logic [CMD_W-1:0]      w_head_data;
    dws_pkg::t_cmd_flags   w_head_flags;

    // Gain registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lap_gain  <= dws_pkg::LAP_GAIN_RESET;
            r_damp_gain <= dws_pkg::DAMP_GAIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dws_pkg::CFG_LAP_GAIN:  r_lap_gain  <= i_cfg_data;
                dws_pkg::CFG_DAMP_GAIN: r_damp_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dws_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cur_value  (i_cur_value),
        .i_old_value  (i_old_value),
        .i_last_point (i_last_point),
        .i_q_not_full (w_q_not_full),
        .o_push       (w_push),
        .o_flags      (w_push_flags),
        .o_left       (w_left),
        .o_center     (w_center),
        .o_old        (w_old),
        .o_right      (w_right)
    );

    dws_fifo #(
        .DATA_W (CMD_W),
        .DEPTH  (dws_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_data  ({w_push_flags, w_left, w_center, w_old, w_right}),
        .o_not_full   (w_q_not_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head_data  (w_head_data)
    );

    assign w_head_flags = w_head_data[CMD_W-1 -: FLAG_W];

    dws_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lap_gain   (r_lap_gain),
        .i_damp_gain  (r_damp_gain),
        .i_head_valid (w_head_valid),
        .i_head_flags (w_head_flags),
        .i_left       (w_head_data[4*VALUE_BITS-1 -: VALUE_BITS]),
        .i_center     (w_head_data[3*VALUE_BITS-1 -: VALUE_BITS]),
        .i_old        (w_head_data[2*VALUE_BITS-1 -: VALUE_BITS]),
        .i_right      (w_head_data[VALUE_BITS-1:0]),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_next_value (o_next_value),
        .o_sweep_end  (o_sweep_end)
    );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the damped 1-D wave leapfrog stencil block.
module tb;

    localparam int VB           = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1700;

    localparam logic [dws_pkg::GAIN_W-1:0] GAIN_ONE =
        dws_pkg::GAIN_W'(24'hFFFFFF) + dws_pkg::GAIN_W'(1);
    localparam logic [dws_pkg::GAIN_W-1:0] GAIN_MAX = '1;

    localparam logic signed [VB-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VB-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [VB-1:0] value;
        logic                 sweep_end;
    } t_wave_result;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // Block ports
    logic                           i_cfg_valid  = 1'b0;
    logic                           o_cfg_ready;
    logic [dws_pkg::CFG_IDX_W-1:0]  i_cfg_index  = dws_pkg::CFG_LAP_GAIN;
    logic [dws_pkg::GAIN_W-1:0]     i_cfg_data   = '0;
    logic                           i_in_valid   = 1'b0;
    logic                           o_in_ready;
    logic signed [VB-1:0]           i_cur_value  = '0;
    logic signed [VB-1:0]           i_old_value  = '0;
    logic                           i_last_point = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready  = 1'b0;
    logic signed [VB-1:0]           o_next_value;
    logic                           o_sweep_end;

    damped_wave_stencil_step #(.VALUE_BITS(VB)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cur_value  (i_cur_value),
        .i_old_value  (i_old_value),
        .i_last_point (i_last_point),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_next_value (o_next_value),
        .o_sweep_end  (o_sweep_end)
    );

    // Stencil state mirror and expected results
    logic [dws_pkg::GAIN_W-1:0] lap_gain_m   = dws_pkg::LAP_GAIN_RESET;
    logic [dws_pkg::GAIN_W-1:0] damp_gain_m  = dws_pkg::DAMP_GAIN_RESET;
    logic signed [VB-1:0]       left_m       = '0;
    logic signed [VB-1:0]       center_m     = '0;
    logic signed [VB-1:0]       center_old_m = '0;
    dws_pkg::t_phase            phase_m      = dws_pkg::PH_WAIT;

    t_wave_result pending_points[$];

    int tx_max         = 0;
    int rx_max         = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // Next value of one inner point: exact sum, each gain term floored, then saturated
    function automatic logic signed [VB-1:0] leapfrog_point(
        input logic signed [VB-1:0] l, input logic signed [VB-1:0] c,
        input logic signed [VB-1:0] o, input logic signed [VB-1:0] r);
        logic signed [63:0] lw, cw, ow, rw, lap, fr, lap_g, damp_g, sum;
        lw     = l;
        cw     = c;
        ow     = o;
        rw     = r;
        lap_g  = $signed({39'd0, lap_gain_m});
        damp_g = $signed({39'd0, damp_gain_m});
        lap    = lw + rw - (cw + cw);
        fr     = cw - ow;
        sum    = (cw + cw) - ow + ((lap * lap_g) >>> dws_pkg::GAIN_FRAC)
                 - ((fr * damp_g) >>> dws_pkg::GAIN_FRAC);
        if (sum > 64'sh0000_0000_7FFF_FFFF)
            return VAL_MAX;
        if (sum < -64'sh0000_0000_8000_0000)
            return VAL_MIN;
        return sum[VB-1:0];
    endfunction

    // Advance the window by one accepted point and queue what it produces
    task automatic advance_stencil(input logic signed [VB-1:0] cur,
                                   input logic signed [VB-1:0] old, input logic last);
        t_wave_result res;
        case (phase_m)
            dws_pkg::PH_WINDOW: begin
                res.value     = leapfrog_point(left_m, center_m, center_old_m,
                                               last ? '0 : cur);
                res.sweep_end = 1'b0;
                pending_points.push_back(res);
                if (last) begin
                    res.value     = '0;
                    res.sweep_end = 1'b1;
                    pending_points.push_back(res);
                    phase_m = dws_pkg::PH_WAIT;
                end else begin
                    left_m       = center_m;
                    center_m     = cur;
                    center_old_m = old;
                end
            end
            dws_pkg::PH_EDGE: begin
                if (last) begin
                    res.value     = '0;
                    res.sweep_end = 1'b1;
                    pending_points.push_back(res);
                    phase_m = dws_pkg::PH_WAIT;
                end else begin
                    center_m     = cur;
                    center_old_m = old;
                    phase_m      = dws_pkg::PH_WINDOW;
                end
            end
            default: begin
                res.value     = '0;
                res.sweep_end = last;
                pending_points.push_back(res);
                left_m  = '0;
                phase_m = last ? dws_pkg::PH_WAIT : dws_pkg::PH_EDGE;
            end
        endcase
    endtask

    // One point transaction on the input channel, after a random gap
    task automatic send_point(input logic signed [VB-1:0] cur,
                              input logic signed [VB-1:0] old, input logic last);
        int gap;
        gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cur_value  <= cur;
        i_old_value  <= old;
        i_last_point <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        advance_stencil(cur, old, last);
    endtask

    // Stop sending and wait until every expected result has left the block
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Gain register write; caller guarantees the block is idle
    task automatic write_gain(input logic [dws_pkg::CFG_IDX_W-1:0] idx,
                              input logic [dws_pkg::GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == dws_pkg::CFG_LAP_GAIN)
            lap_gain_m = data;
        else
            damp_gain_m = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_gains(input logic [dws_pkg::GAIN_W-1:0] lap,
                             input logic [dws_pkg::GAIN_W-1:0] damp);
        settle_idle();
        write_gain(dws_pkg::CFG_LAP_GAIN, lap);
        write_gain(dws_pkg::CFG_DAMP_GAIN, damp);
    endtask

    // Field value: 0 smooth around zero, 1 full range, 2 extremes mixed in
    function automatic logic signed [VB-1:0] pick_value(input int style);
        case (style)
            0: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            1: return $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    3: return -32'sd1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic run_sweep(input int len, input int style);
        for (int i = 0; i < len; i++)
            send_point(pick_value(style), pick_value(style), i == len - 1);
    endtask

    // Short grids, saturation both ways, floor rounding, at default gains
    task automatic test_directed();
        tx_max = 0;
        rx_max = 0;
        // one-point sweep
        send_point(32'sd5, 32'sd7, 1'b1);
        // two-point sweep
        send_point(VAL_MAX, VAL_MIN, 1'b0);
        send_point(VAL_MIN, VAL_MAX, 1'b1);
        // saturates high
        send_point(VAL_MIN, VAL_MIN, 1'b0);
        send_point(VAL_MAX, VAL_MIN, 1'b0);
        send_point(VAL_MAX, VAL_MAX, 1'b1);
        // saturates low
        send_point(VAL_MAX, VAL_MAX, 1'b0);
        send_point(VAL_MIN, VAL_MAX, 1'b0);
        send_point(VAL_MIN, VAL_MIN, 1'b1);
        // negative laplacian term floors toward minus infinity
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(32'sd0, 32'sd3, 1'b0);
        send_point(-32'sd1, 32'sd0, 1'b0);
        send_point(32'sd1, -32'sd1, 1'b0);
        send_point(32'sd0, 32'sd0, 1'b1);
    endtask

    // Gain corners: zero, unity, largest register value, mixed
    task automatic test_gain_extremes();
        logic [dws_pkg::GAIN_W-1:0] laps [5];
        logic [dws_pkg::GAIN_W-1:0] damps[5];
        laps  = '{'0, GAIN_ONE, GAIN_ONE, GAIN_MAX, '0};
        damps = '{'0, '0, GAIN_ONE, GAIN_MAX, GAIN_MAX};
        tx_max = 17;
        rx_max = 17;
        for (int k = 0; k < 5; k++) begin
            set_gains(laps[k], damps[k]);
            run_sweep(5, 2);
            run_sweep(8, 0);
        end
    endtask

    // Random sweeps of mixed lengths with gains changed between phases
    task automatic test_random_sweeps();
        int sent;
        int len;
        int style;
        sent = 0;
        for (int blk = 0; blk < 4; blk++) begin
            if (blk == 3)
                set_gains(dws_pkg::LAP_GAIN_RESET, dws_pkg::DAMP_GAIN_RESET);
            else
                set_gains(dws_pkg::GAIN_W'($urandom_range(0, 32'h0100_0000)),
                          dws_pkg::GAIN_W'($urandom_range(0, 32'h0100_0000)));
            while (sent < (blk + 1) * RANDOM_ITEMS / 4) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(1, 2);
                    1:       len = $urandom_range(40, 80);
                    default: len = $urandom_range(3, 20);
                endcase
                case ($urandom_range(0, 5))
                    0:       style = 1;
                    1:       style = 2;
                    default: style = 0;
                endcase
                tx_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
                rx_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
                run_sweep(len, style);
                sent += len;
            end
        end
    endtask

    // Result checker and receiver stall generator
    always @(posedge i_clk) begin : result_check
        t_wave_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: next_value %0d sweep_end %0b",
                             o_next_value, o_sweep_end);
                mismatch_count++;
            end else begin
                want = pending_points.pop_front();
                if (o_next_value !== want.value || o_sweep_end !== want.sweep_end) begin
                    if (mismatch_count < 10)
                        $display("mismatch: next_value exp %0d got %0d, sweep_end exp %0b got %0b",
                                 want.value, o_next_value, want.sweep_end, o_sweep_end);
                    mismatch_count++;
                end
            end
            stall_left = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_out_ready <= (stall_left == 0);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("damped_wave_stencil_step regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_gain_extremes();
        test_random_sweeps();
        settle_idle();
        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("damped_wave_stencil_step regression: pass");
        else
            $display("damped_wave_stencil_step regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dws_pkg.sv
rtl/core/dws_fifo.sv
rtl/core/dws_front.sv
rtl/core/dws_back.sv
rtl/core/damped_wave_stencil_step.sv
tb/sv/tb.sv
